// ===== rtl/calc_pkg.sv =====
// shared constants, codes and types of the card access-list controller
package calc_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int UID_W     = 32;
    localparam int TICK_W    = 16;
    localparam int EVENT_W   = 3;
    localparam int STORED_W  = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    // reset value of the idle timeout
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd10000;

    // result event codes
    localparam logic [EVENT_W-1:0] EV_ENTER   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_ADDED   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_REMOVED = 3'd2;
    localparam logic [EVENT_W-1:0] EV_GRANTED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_DENIED  = 3'd4;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd5;
    localparam logic [EVENT_W-1:0] EV_FULL    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MASTER_UID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    // input item mode codes
    localparam logic MODE_CARD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // configuration seen by the controller
    typedef struct packed {
        logic [UID_W-1:0]  master_uid;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic [STORED_W-1:0] stored_cards;
    } res_t;

endpackage

// ===== rtl/calc_if.sv =====
// valid/ready channel interfaces for card items and result items

// card or tick channel
interface calc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [calc_pkg::UID_W-1:0]  card_uid;

    modport source (output valid, output mode, output card_uid, input ready);
    modport sink   (input valid, input mode, input card_uid, output ready);
    modport mon    (input valid, input ready, input mode, input card_uid);
endinterface

// result channel
interface calc_out_if;
    logic                           valid;
    logic                           ready;
    logic [calc_pkg::EVENT_W-1:0]   event_res;
    logic [calc_pkg::STORED_W-1:0]  stored_cards;

    modport source (output valid, output event_res, output stored_cards, input ready);
    modport sink   (input valid, input event_res, input stored_cards, output ready);
    modport mon    (input valid, input ready, input event_res, input stored_cards);
endinterface

// ===== rtl/calc_ram.sv =====
// simple dual-port table memory, one write port and one registered read port
module calc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/calc_ctrl.sv =====
// sequencer: mode handling, table search, shift-down removal and append
module calc_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  calc_pkg::cfg_t                 cfg,
    // input item
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_mode,
    input  logic [calc_pkg::UID_W-1:0]     in_uid,
    // result towards the output register
    output logic                           res_valid,
    input  logic                           res_ready,
    output calc_pkg::res_t                 res,
    // table memory
    output logic                           ram_wr_en,
    output logic [calc_pkg::IDX_W-1:0]     ram_wr_addr,
    output logic [calc_pkg::UID_W-1:0]     ram_wr_data,
    output logic [calc_pkg::IDX_W-1:0]     ram_rd_addr,
    input  logic [calc_pkg::UID_W-1:0]     ram_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_RESOLVE,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t                             state_reg, state_next;
    logic                               prog_reg, prog_next;
    logic [calc_pkg::TICK_W-1:0]        idle_reg, idle_next;
    logic [calc_pkg::CNT_W-1:0]         total_reg, total_next;
    logic [calc_pkg::UID_W-1:0]         uid_reg, uid_next;
    logic [calc_pkg::CNT_W-1:0]         iss_reg, iss_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic [calc_pkg::CNT_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                               found_reg, found_next;
    logic [calc_pkg::CNT_W-1:0]         pos_reg, pos_next;
    logic [calc_pkg::EVENT_W-1:0]       ev_reg, ev_next;

    logic                               issue;
    logic                               match;
    logic [calc_pkg::CNT_W-1:0]         shift_dst;

    // a read is issued while the walk pointer is below the fill count
    assign issue     = (iss_reg < total_reg);
    // read data belongs to the entry issued in the previous cycle
    assign match     = pend_valid_reg && (ram_rd_data == uid_reg);
    assign shift_dst = pend_idx_reg - calc_pkg::CNT_W'(1);

    assign ram_rd_addr = iss_reg[calc_pkg::IDX_W-1:0];

    assign in_ready           = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_DONE);
    assign res.event_res      = ev_reg;
    assign res.stored_cards   = calc_pkg::STORED_W'(total_reg);

    // next-state logic
    always_comb
    begin
        state_next      = state_reg;
        prog_next       = prog_reg;
        idle_next       = idle_reg;
        total_next      = total_reg;
        uid_next        = uid_reg;
        iss_next        = iss_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        pos_next        = pos_reg;
        ev_next         = ev_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = total_reg[calc_pkg::IDX_W-1:0];
        ram_wr_data     = uid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == calc_pkg::MODE_TICK)
                    begin
                        // ticks only matter in programming mode
                        if (prog_reg)
                        begin
                            if (idle_reg >= cfg.timeout_ticks)
                            begin
                                prog_next  = 1'b0;
                                ev_next    = calc_pkg::EV_TIMEOUT;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idle_next = idle_reg + calc_pkg::TICK_W'(1);
                            end
                        end
                    end
                    else if (in_uid == cfg.master_uid)
                    begin
                        // master card always (re)opens programming mode
                        prog_next  = 1'b1;
                        idle_next  = '0;
                        ev_next    = calc_pkg::EV_ENTER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        uid_next        = in_uid;
                        iss_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // pipelined walk: issue one read, compare the previous one
                pend_valid_next = issue;
                pend_idx_next   = iss_reg;
                if (issue)
                begin
                    iss_next = iss_reg + calc_pkg::CNT_W'(1);
                end
                if (match)
                begin
                    found_next      = 1'b1;
                    pos_next        = pend_idx_reg;
                    pend_valid_next = 1'b0;
                    state_next      = S_RESOLVE;
                end
                else if (!pend_valid_reg && !issue)
                begin
                    found_next = 1'b0;
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                if (prog_reg)
                begin
                    idle_next = '0;
                    if (found_reg)
                    begin
                        // start shifting the later entries down by one
                        iss_next        = pos_reg + calc_pkg::CNT_W'(1);
                        pend_valid_next = 1'b0;
                        state_next      = S_SHIFT;
                    end
                    else if (total_reg >= calc_pkg::CNT_W'(calc_pkg::TABLE_DEPTH))
                    begin
                        ev_next    = calc_pkg::EV_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // append at the fill count
                        ram_wr_en  = 1'b1;
                        total_next = total_reg + calc_pkg::CNT_W'(1);
                        ev_next    = calc_pkg::EV_ADDED;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ev_next    = found_reg ? calc_pkg::EV_GRANTED : calc_pkg::EV_DENIED;
                    state_next = S_DONE;
                end
            end

            S_SHIFT:
            begin
                // read entry k+1 now, write it to entry k next cycle
                pend_valid_next = issue;
                pend_idx_next   = iss_reg;
                if (issue)
                begin
                    iss_next = iss_reg + calc_pkg::CNT_W'(1);
                end
                if (pend_valid_reg)
                begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = shift_dst[calc_pkg::IDX_W-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (!pend_valid_reg && !issue)
                begin
                    total_next = total_reg - calc_pkg::CNT_W'(1);
                    ev_next    = calc_pkg::EV_REMOVED;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prog_reg       <= 1'b0;
            idle_reg       <= '0;
            total_reg      <= '0;
            pend_valid_reg <= 1'b0;
            iss_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            prog_reg       <= prog_next;
            idle_reg       <= idle_next;
            total_reg      <= total_next;
            pend_valid_reg <= pend_valid_next;
            iss_reg        <= iss_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        uid_reg      <= uid_next;
        pend_idx_reg <= pend_idx_next;
        found_reg    <= found_next;
        pos_reg      <= pos_next;
        ev_reg       <= ev_next;
    end

endmodule

// ===== rtl/card_access_list_controller_unit.sv =====
// top level of the card access-list controller: config registers, output register
//
// Each input beat is a presented card or one time tick; each card beat yields one
// result beat, a tick yields one only when it ends programming mode. A card other
// than the master card walks the card table, which sits in a single memory with one
// read and one write port, the read port registered: the search stops at the hit,
// and a removal then shifts the later entries down at one entry per cycle, so search
// and shift together pass over the table once. One item is worked on at a time; a
// finished result waits in the output register while the next item is taken. The
// table needs no clearing after reset: only entries below the fill count are ever
// read.
module card_access_list_controller_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    calc_in_if.sink                         card_in,
    calc_out_if.source                      event_out,
    input  logic                            cfg_we,
    input  logic [calc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [calc_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

    calc_pkg::cfg_t                    cfg_reg;
    logic                              out_valid_reg;
    calc_pkg::res_t                    out_res_reg;

    logic                              res_valid;
    logic                              res_ready;
    calc_pkg::res_t                    res;

    logic                              ram_wr_en;
    logic [calc_pkg::IDX_W-1:0]        ram_wr_addr;
    logic [calc_pkg::UID_W-1:0]        ram_wr_data;
    logic [calc_pkg::IDX_W-1:0]        ram_rd_addr;
    logic [calc_pkg::UID_W-1:0]        ram_rd_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.master_uid    <= '0;
            cfg_reg.timeout_ticks <= calc_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                calc_pkg::REG_MASTER_UID:
                begin
                    cfg_reg.master_uid <= cfg_wdata[calc_pkg::UID_W-1:0];
                end
                calc_pkg::REG_TIMEOUT_TICKS:
                begin
                    cfg_reg.timeout_ticks <= cfg_wdata[calc_pkg::TICK_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // output register, free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || event_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign event_out.valid        = out_valid_reg;
    assign event_out.event_res    = out_res_reg.event_res;
    assign event_out.stored_cards = out_res_reg.stored_cards;

    // sequencer
    calc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (card_in.valid),
        .in_ready    (card_in.ready),
        .in_mode     (card_in.mode),
        .in_uid      (card_in.card_uid),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // card table
    calc_ram #(
        .DEPTH (calc_pkg::TABLE_DEPTH),
        .WIDTH (calc_pkg::UID_W),
        .AW    (calc_pkg::IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// ===== rtl/calc_chk.sv =====
// port-level checker for the card access-list controller, bound to the top level
module calc_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           in_mode,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [calc_pkg::EVENT_W-1:0]   out_event,
    input  logic [calc_pkg::STORED_W-1:0]  out_stored
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_event) && $stable(out_stored))
        else $error("result payload changed while stalled");

    // a taken card beat leaves the block busy in the next cycle
    a_card_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == calc_pkg::MODE_CARD) |=> !in_ready)
        else $error("card taken without a busy cycle");

    // an added card leaves the table non-empty
    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_event == calc_pkg::EV_ADDED) |-> (out_stored != '0))
        else $error("card added but table reported empty");

    // only defined event codes leave the block
    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_event <= calc_pkg::EV_FULL))
        else $error("undefined event code");

endmodule

bind card_access_list_controller_unit calc_chk u_calc_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (card_in.valid),
    .in_ready   (card_in.ready),
    .in_mode    (card_in.mode),
    .out_valid  (event_out.valid),
    .out_ready  (event_out.ready),
    .out_event  (event_out.event_res),
    .out_stored (event_out.stored_cards)
);
